@@ sv/sws_pkg.sv @@
// Shared types, constants and microcode program for the stack with sum queries.
package sws_pkg;

  // Stack geometry.
  localparam int DEPTH  = 1024;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int PTR_W  = $clog2(DEPTH + 1);
  localparam int WORD_W = 32;
  localparam int CNT_W  = 11;
  localparam int OP_W   = 3;

  // Command codes.
  localparam logic [OP_W-1:0] OP_PUSH   = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_N = 3'd1;
  localparam logic [OP_W-1:0] OP_POP    = 3'd2;
  localparam logic [OP_W-1:0] OP_POP_N  = 3'd3;
  localparam logic [OP_W-1:0] OP_SUM    = 3'd4;

  // Microcode addresses.
  typedef enum logic [2:0] {
    U_FETCH,
    U_PUSH,
    U_POP,
    U_SUM,
    U_EMIT
  } upc_t;

  // Jump conditions; when the condition is false the step repeats.
  typedef enum logic [2:0] {
    C_ALWAYS,
    C_DISPATCH,
    C_PUSH_END,
    C_POP_END,
    C_OUT_TAKEN
  } cond_t;

  // Datapath controls of one step.
  typedef struct packed {
    logic accept;
    logic push;
    logic pop;
    logic ld_total;
    logic emit;
  } ctrl_t;

  // One control word.
  typedef struct packed {
    cond_t cond;
    upc_t  target;
    ctrl_t ctl;
  } uword_t;

  // Datapath status seen by the sequencer.
  typedef struct packed {
    logic            in_fire;
    logic [OP_W-1:0] op;
    logic            cnt_zero;
    logic            full;
    logic            empty;
    logic            out_fire;
  } status_t;

  // The program: fetch, push loop, pop loop, sum load and result hand-off.
  function automatic uword_t urom(upc_t pc);
    uword_t w;
    w = '{cond: C_ALWAYS, target: U_FETCH, ctl: '0};
    unique case (pc)
      U_FETCH: w = '{cond: C_DISPATCH,  target: U_FETCH,
                     ctl: '{accept: 1'b1, default: 1'b0}};
      U_PUSH:  w = '{cond: C_PUSH_END,  target: U_FETCH,
                     ctl: '{push: 1'b1, default: 1'b0}};
      U_POP:   w = '{cond: C_POP_END,   target: U_EMIT,
                     ctl: '{pop: 1'b1, default: 1'b0}};
      U_SUM:   w = '{cond: C_ALWAYS,    target: U_EMIT,
                     ctl: '{ld_total: 1'b1, default: 1'b0}};
      U_EMIT:  w = '{cond: C_OUT_TAKEN, target: U_FETCH,
                     ctl: '{emit: 1'b1, default: 1'b0}};
      default: w = '{cond: C_ALWAYS,    target: U_FETCH, ctl: '0};
    endcase
    return w;
  endfunction

  // Entry point of each command; unknown commands go straight back to fetch.
  function automatic upc_t dispatch(logic [OP_W-1:0] op);
    upc_t pc;
    unique case (op) inside
      OP_PUSH, OP_PUSH_N: pc = U_PUSH;
      OP_POP, OP_POP_N:   pc = U_POP;
      OP_SUM:             pc = U_SUM;
      default:            pc = U_FETCH;
    endcase
    return pc;
  endfunction

endpackage

@@ sv/sws_if.sv @@
// Command and response channel interfaces of the stack.
interface sws_cmd_if;
  import sws_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          op;
  logic signed [WORD_W-1:0] value;
  logic [CNT_W-1:0]         count;
  modport source (output valid, output op, output value, output count, input ready);
  modport sink (input valid, input op, input value, input count, output ready);
endinterface

interface sws_rsp_if;
  import sws_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [WORD_W-1:0] result;
  logic                     overflow;
  logic [CNT_W-1:0]         depth_now;
  modport source (output valid, output result, output overflow, output depth_now,
                  input ready);
  modport sink (input valid, input result, input overflow, input depth_now,
                output ready);
endinterface

@@ sv/sws_seq.sv @@
// Microcode sequencer: step counter, program table and conditional jumps.
module sws_seq (
  input  logic             clk,
  input  logic             rst,
  input  sws_pkg::status_t status,
  output sws_pkg::ctrl_t   ctrl
);
  import sws_pkg::*;

  upc_t   upc;
  upc_t   upc_next;
  uword_t uw;
  logic   taken;

  // Step counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= U_FETCH;
    end else begin
      upc <= upc_next;
    end
  end

  // Decode the current control word and pick the next step.
  always_comb begin
    uw   = urom(upc);
    ctrl = uw.ctl;
    unique case (uw.cond)
      C_ALWAYS:    taken = 1'b1;
      C_DISPATCH:  taken = status.in_fire;
      C_PUSH_END:  taken = status.cnt_zero || status.full;
      C_POP_END:   taken = status.cnt_zero || status.empty;
      C_OUT_TAKEN: taken = status.out_fire;
      default:     taken = 1'b1;
    endcase
    if (!taken) begin
      upc_next = upc;
    end else if (uw.cond == C_DISPATCH) begin
      upc_next = dispatch(status.op);
    end else begin
      upc_next = uw.target;
    end
  end

endmodule

@@ sv/sws_dp.sv @@
// Datapath: stack memory, pointer, running total, loop counter and accumulator.
module sws_dp (
  input  logic                              clk,
  input  logic                              rst,
  input  sws_pkg::ctrl_t                    ctrl,
  input  logic                              in_fire,
  input  logic [sws_pkg::OP_W-1:0]          op,
  input  logic signed [sws_pkg::WORD_W-1:0] value,
  input  logic [sws_pkg::CNT_W-1:0]         count,
  output logic                              cnt_zero,
  output logic                              full,
  output logic                              empty,
  output logic signed [sws_pkg::WORD_W-1:0] result,
  output logic                              overflow,
  output logic [sws_pkg::CNT_W-1:0]         depth_now
);
  import sws_pkg::*;

  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] rdata;
  logic [WORD_W-1:0] value_r;
  logic [WORD_W-1:0] total;
  logic [WORD_W-1:0] acc;
  logic [PTR_W-1:0]  sp;
  logic [PTR_W-1:0]  sp_dec;
  logic [CNT_W-1:0]  cnt;
  logic              rd_valid;
  logic              push_do;
  logic              pop_do;

  assign cnt_zero = (cnt == '0);
  assign full     = (sp == PTR_W'(DEPTH));
  assign empty    = (sp == '0);
  assign sp_dec   = sp - 1'b1;
  assign push_do  = ctrl.push && !cnt_zero && !full;
  assign pop_do   = ctrl.pop && !cnt_zero && !empty;

  // Stack memory, one write or one registered read per cycle.
  always_ff @(posedge clk) begin
    if (push_do) begin
      mem[sp[ADDR_W-1:0]] <= value_r;
    end
    if (pop_do) begin
      rdata <= mem[sp_dec[ADDR_W-1:0]];
    end
  end

  // Control registers: pointer, total, sticky flag, loop counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      sp       <= '0;
      total    <= '0;
      overflow <= 1'b0;
      cnt      <= '0;
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= pop_do;
      if (ctrl.accept && in_fire) begin
        cnt <= (op == OP_PUSH || op == OP_POP) ? CNT_W'(1) : count;
      end else if (push_do || pop_do || (ctrl.push && !cnt_zero)) begin
        cnt <= cnt - 1'b1;
      end
      if (push_do) begin
        sp    <= sp + 1'b1;
        total <= total + value_r;
      end else if (pop_do) begin
        sp <= sp_dec;
      end
      if (rd_valid) begin
        total <= total - rdata;
      end
      if (ctrl.push && !cnt_zero && full) begin
        overflow <= 1'b1;
      end
    end
  end

  // Payload registers: pushed word and result accumulator.
  always_ff @(posedge clk) begin
    if (ctrl.accept && in_fire) begin
      value_r <= value;
      acc     <= '0;
    end else if (ctrl.ld_total) begin
      acc <= total;
    end else if (rd_valid) begin
      acc <= acc + rdata;
    end
  end

  assign result    = acc;
  assign depth_now = CNT_W'(sp);

endmodule

@@ sv/stack_with_sum_queries_top.sv @@
// Top level: LIFO stack of signed words with pop-sum and sum-all queries.
// Flow: a command word is accepted, then push and push copies store min(count, room)
// words, pop and pop count remove min(count, depth) words, sum loads the total, and
// pop and sum then hold a result word until taken. No new command is accepted until
// the last one is done; the memory's single port sets the loop pace.
// Reset clears the pointer, total, overflow flag and sequencer; memory needs no clear.
module stack_with_sum_queries_top (
  input logic     clk,
  input logic     rst,
  sws_cmd_if.sink   cmd,
  sws_rsp_if.source rsp
);
  import sws_pkg::*;

  ctrl_t   ctrl;
  status_t status;
  logic    cnt_zero;
  logic    full;
  logic    empty;

  // Handshakes follow the current control word.
  assign cmd.ready = ctrl.accept;
  assign rsp.valid = ctrl.emit;

  // Status back to the sequencer.
  always_comb begin
    status.in_fire  = cmd.valid && cmd.ready;
    status.op       = cmd.op;
    status.cnt_zero = cnt_zero;
    status.full     = full;
    status.empty    = empty;
    status.out_fire = rsp.valid && rsp.ready;
  end

  sws_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .ctrl   (ctrl)
  );

  sws_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .in_fire   (status.in_fire),
    .op        (cmd.op),
    .value     (cmd.value),
    .count     (cmd.count),
    .cnt_zero  (cnt_zero),
    .full      (full),
    .empty     (empty),
    .result    (rsp.result),
    .overflow  (rsp.overflow),
    .depth_now (rsp.depth_now)
  );

endmodule
